FILE: src/dstwr_pkg.sv
// ----------------------------------------------------------------------------
// dstwr_pkg: shared widths and types of the ranging distance unit
// Timestamp, interval, product and quotient widths, and the word that the
// front part hands to the back part through the queue.
// ----------------------------------------------------------------------------
package dstwr_pkg;

	localparam int STAMP_W    = 40;
	localparam int IV_W       = 32;
	localparam int DLY_W      = 16;
	localparam int PROD_W     = 2 * IV_W;
	localparam int DEN_W      = IV_W + 2;
	localparam int MUL15_SHIFT = 4;
	localparam int MAG15_W    = PROD_W + MUL15_SHIFT;
	localparam int DIST_SHIFT = 5;
	localparam int OUT_W      = 40;
	localparam int QB         = OUT_W + 1;

	typedef struct packed {
		logic [PROD_W-1:0]  mag;
		logic [MAG15_W-1:0] mag15;
		logic [DEN_W-1:0]   den;
		logic               neg;
		logic               pos;
	} work_t;

endpackage

FILE: src/dstwr_if.sv
// ----------------------------------------------------------------------------
// dstwr_if: stream channels of the ranging distance unit
// Timestamp channel into the unit and result channel out of it, each with
// valid, ready and payload.
// ----------------------------------------------------------------------------
interface dstwr_in_if;
	logic                         valid;
	logic                         ready;
	logic [dstwr_pkg::STAMP_W-1:0] poll_tx_time;
	logic [dstwr_pkg::STAMP_W-1:0] resp_rx_time;
	logic [dstwr_pkg::STAMP_W-1:0] final_tx_time;
	logic [dstwr_pkg::STAMP_W-1:0] poll_rx_time;
	logic [dstwr_pkg::STAMP_W-1:0] resp_tx_time;
	logic [dstwr_pkg::STAMP_W-1:0] final_rx_time;

	modport source (
		output valid, poll_tx_time, resp_rx_time, final_tx_time,
		output poll_rx_time, resp_tx_time, final_rx_time,
		input  ready
	);
	modport sink (
		input  valid, poll_tx_time, resp_rx_time, final_tx_time,
		input  poll_rx_time, resp_tx_time, final_rx_time,
		output ready
	);
endinterface

interface dstwr_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [dstwr_pkg::OUT_W-1:0] tof_q8;
	logic signed [dstwr_pkg::OUT_W-1:0] distance_q8;
	logic                               tof_positive;
	logic                               zero_divisor;

	modport source (
		output valid, tof_q8, distance_q8, tof_positive, zero_divisor,
		input  ready
	);
	modport sink (
		input  valid, tof_q8, distance_q8, tof_positive, zero_divisor,
		output ready
	);
endinterface

FILE: src/dstwr_front.sv
// ----------------------------------------------------------------------------
// dstwr_front: timestamp front end
// Corrects responder stamps by the antenna delay, forms the four intervals,
// the two products and the divisor, and classifies the numerator sign.
// ----------------------------------------------------------------------------
module dstwr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dstwr_pkg::DLY_W-1:0]   antenna_delay,
	dstwr_in_if.sink                      stamps,
	output logic                          push_valid,
	input  logic                          push_ready,
	output dstwr_pkg::work_t              push_data
);
	import dstwr_pkg::*;

	logic              en;
	logic              v_s1, v_s2, v_s3, v_s4;
	logic [IV_W-1:0]   dly;
	logic [IV_W-1:0]   poll_rx_c, resp_tx_c, final_rx_c;
	logic [IV_W-1:0]   round1_s1, reply1_s1, round2_s1, reply2_s1;
	logic [PROD_W-1:0] p1_s2, p2_s2;
	logic [DEN_W-1:0]  den_s2, den_s3, den_s4;
	logic [PROD_W-1:0] mag_s3, mag_s4;
	logic              neg_s3, neg_s4, pos_s4;
	logic [MAG15_W-1:0] mag15_s4;

	assign en           = !(v_s4 && !push_ready);
	assign stamps.ready = en;

	assign dly        = IV_W'(antenna_delay);
	assign poll_rx_c  = stamps.poll_rx_time[IV_W-1:0] - dly;
	assign resp_tx_c  = stamps.resp_tx_time[IV_W-1:0] + dly;
	assign final_rx_c = stamps.final_rx_time[IV_W-1:0] - dly;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= stamps.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			round1_s1 <= stamps.resp_rx_time[IV_W-1:0] - stamps.poll_tx_time[IV_W-1:0];
			reply1_s1 <= resp_tx_c - poll_rx_c;
			round2_s1 <= final_rx_c - resp_tx_c;
			reply2_s1 <= stamps.final_tx_time[IV_W-1:0] - stamps.resp_rx_time[IV_W-1:0];

			p1_s2  <= PROD_W'(round1_s1) * PROD_W'(round2_s1);
			p2_s2  <= PROD_W'(reply1_s1) * PROD_W'(reply2_s1);
			den_s2 <= DEN_W'(round1_s1) + DEN_W'(round2_s1)
			        + DEN_W'(reply1_s1) + DEN_W'(reply2_s1);

			neg_s3 <= p1_s2 < p2_s2;
			mag_s3 <= (p1_s2 < p2_s2) ? p2_s2 - p1_s2 : p1_s2 - p2_s2;
			den_s3 <= den_s2;

			mag_s4   <= mag_s3;
			mag15_s4 <= (MAG15_W'(mag_s3) << MUL15_SHIFT) - MAG15_W'(mag_s3);
			neg_s4   <= neg_s3;
			pos_s4   <= !neg_s3 && (mag_s3 != '0);
			den_s4   <= den_s3;
		end
	end

	assign push_valid      = v_s4;
	assign push_data.mag   = mag_s4;
	assign push_data.mag15 = mag15_s4;
	assign push_data.den   = den_s4;
	assign push_data.neg   = neg_s4;
	assign push_data.pos   = pos_s4;

endmodule

FILE: src/dstwr_queue.sv
// ----------------------------------------------------------------------------
// dstwr_queue: short queue between front and back
// Holds classified words so that either side can stall on its own.
// ----------------------------------------------------------------------------
module dstwr_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  dstwr_pkg::work_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output dstwr_pkg::work_t pop_data
);
	import dstwr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	work_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

FILE: src/dstwr_back.sv
// ----------------------------------------------------------------------------
// dstwr_back: divider pipeline and output stage
// Two restoring dividers, one quotient bit per stage, produce the rounded
// tof and distance; the last stage saturates and holds the result word.
// ----------------------------------------------------------------------------
module dstwr_back #(
	parameter int FRAC_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  dstwr_pkg::work_t pop_data,
	dstwr_out_if.source      result
);
	import dstwr_pkg::*;

	localparam int TN_W = PROD_W + FRAC_BITS + 1;
	localparam int DN_W = MAG15_W + FRAC_BITS + 1;
	localparam int TT_W = TN_W - QB;
	localparam int DT_W = DN_W - QB;
	localparam int TD_W = DEN_W;
	localparam int DD_W = DEN_W + DIST_SHIFT;
	localparam int TC_W = (TT_W > TD_W) ? TT_W : TD_W;
	localparam int DC_W = (DT_W > DD_W) ? DT_W : DD_W;
	localparam logic [QB-1:0] POS_LIM = QB'((64'd1 << (OUT_W - 1)) - 64'd1);
	localparam logic [QB-1:0] NEG_LIM = QB'(64'd1 << (OUT_W - 1));

	logic                en;
	logic [TN_W-1:0]     tn;
	logic [DN_W-1:0]     dn;
	logic [DD_W-1:0]     dden0;

	logic [QB:0]         v_s;
	logic [TD_W-1:0]     trem_s [QB+1];
	logic [DD_W-1:0]     drem_s [QB+1];
	logic [QB-1:0]       tlow_s [QB+1];
	logic [QB-1:0]       dlow_s [QB+1];
	logic [QB-1:0]       tq_s   [QB+1];
	logic [QB-1:0]       dq_s   [QB+1];
	logic [DEN_W-1:0]    den_s  [QB+1];
	logic [QB:0]         tovf_s, dovf_s, neg_s, pos_s;

	logic                out_v_q;
	logic [OUT_W-1:0]    tof_q, dist_q;
	logic                pos_q, zero_q;

	logic [QB:0]         trnd, drnd;
	logic                zero_f;

	function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic ovf,
		input logic [QB-1:0] mag);
		logic [OUT_W-1:0] r;
		if (neg) begin
			if (ovf || mag > NEG_LIM) begin
				r = {1'b1, {(OUT_W-1){1'b0}}};
			end else begin
				r = '0 - mag[OUT_W-1:0];
			end
		end else begin
			if (ovf || mag > POS_LIM) begin
				r = {1'b0, {(OUT_W-1){1'b1}}};
			end else begin
				r = mag[OUT_W-1:0];
			end
		end
		return r;
	endfunction

	assign en        = !out_v_q || result.ready;
	assign pop_ready = en;

	assign tn    = TN_W'(pop_data.mag) << (FRAC_BITS + 1);
	assign dn    = DN_W'(pop_data.mag15) << (FRAC_BITS + 1);
	assign dden0 = DD_W'(pop_data.den) << DIST_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tovf_s[0] <= TC_W'(tn[TN_W-1:QB]) >= TC_W'(pop_data.den);
			dovf_s[0] <= DC_W'(dn[DN_W-1:QB]) >= DC_W'(dden0);
			trem_s[0] <= TD_W'(tn[TN_W-1:QB]);
			drem_s[0] <= DD_W'(dn[DN_W-1:QB]);
			tlow_s[0] <= tn[QB-1:0];
			dlow_s[0] <= dn[QB-1:0];
			tq_s[0]   <= '0;
			dq_s[0]   <= '0;
			den_s[0]  <= pop_data.den;
			neg_s[0]  <= pop_data.neg;
			pos_s[0]  <= pop_data.pos;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_div
		logic [TD_W:0]   ttrial;
		logic [DD_W:0]   dtrial;
		logic [DD_W-1:0] dden;
		logic            tge, dge;

		assign dden   = DD_W'(den_s[k-1]) << DIST_SHIFT;
		assign ttrial = {trem_s[k-1], tlow_s[k-1][QB-1]};
		assign dtrial = {drem_s[k-1], dlow_s[k-1][QB-1]};
		assign tge    = ttrial >= (TD_W+1)'(den_s[k-1]);
		assign dge    = dtrial >= (DD_W+1)'(dden);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				trem_s[k] <= tge ? TD_W'(ttrial - (TD_W+1)'(den_s[k-1])) : ttrial[TD_W-1:0];
				drem_s[k] <= dge ? DD_W'(dtrial - (DD_W+1)'(dden)) : dtrial[DD_W-1:0];
				tlow_s[k] <= tlow_s[k-1] << 1;
				dlow_s[k] <= dlow_s[k-1] << 1;
				tq_s[k]   <= {tq_s[k-1][QB-2:0], tge};
				dq_s[k]   <= {dq_s[k-1][QB-2:0], dge};
				den_s[k]  <= den_s[k-1];
				tovf_s[k] <= tovf_s[k-1];
				dovf_s[k] <= dovf_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				pos_s[k]  <= pos_s[k-1];
			end
		end
	end

	assign trnd   = (QB+1)'(tq_s[QB]) + (QB+1)'(1);
	assign drnd   = (QB+1)'(dq_s[QB]) + (QB+1)'(1);
	assign zero_f = den_s[QB] == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_f) begin
				tof_q  <= '0;
				dist_q <= '0;
				pos_q  <= 1'b0;
				zero_q <= 1'b1;
			end else begin
				tof_q  <= sat_out(neg_s[QB], tovf_s[QB], trnd[QB:1]);
				dist_q <= sat_out(neg_s[QB], dovf_s[QB], drnd[QB:1]);
				pos_q  <= pos_s[QB];
				zero_q <= 1'b0;
			end
		end
	end

	assign result.valid        = out_v_q;
	assign result.tof_q8       = tof_q;
	assign result.distance_q8  = dist_q;
	assign result.tof_positive = pos_q;
	assign result.zero_divisor = zero_q;

`ifndef SYNTH
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && zero_q) |-> (tof_q == '0 && dist_q == '0 && !pos_q))
		else $error("zero divisor word carries nonzero result");
	a_pos_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && pos_q) |-> !tof_q[OUT_W-1])
		else $error("positive numerator gave negative tof");
	a_dist_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && tof_q[OUT_W-1]) |-> (dist_q[OUT_W-1] || dist_q == '0))
		else $error("distance sign disagrees with tof");
`endif

endmodule

FILE: src/ds_twr_tof_distance_unit.sv
// ----------------------------------------------------------------------------
// ds_twr_tof_distance_unit: double-sided two-way ranging distance unit
// Turns the six timestamps of one ranging exchange into a Q-format time of
// flight and distance.
//
//   channel  | dir | word
//   stamps   | in  | six 40-bit radio timestamps of one exchange
//   result   | out | tof_q8, distance_q8, tof_positive, zero_divisor
//   cfg      | in  | cfg_we / cfg_wdata, 16-bit antenna delay
//
// One word per cycle sustained while result is ready. The path runs through 4
// front stages, the queue, 1 setup stage, 41 divider stages (one quotient
// bit each) and 1 output stage. The queue holds QUEUE_DEPTH words so the
// front keeps taking words while a result waits, until the queue is full.
// Reset is asynchronous, active low; antenna delay resets to zero.
// ----------------------------------------------------------------------------
module ds_twr_tof_distance_unit #(
	parameter int FRAC_BITS   = 8,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dstwr_pkg::DLY_W-1:0] cfg_wdata,
	dstwr_in_if.sink                    stamps,
	dstwr_out_if.source                 result
);
	import dstwr_pkg::*;

	logic [DLY_W-1:0] dly_q;
	logic             push_valid, push_ready;
	logic             pop_valid, pop_ready;
	work_t            push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_q <= '0;
		end else if (cfg_we) begin
			dly_q <= cfg_wdata;
		end
	end

	dstwr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.antenna_delay (dly_q),
		.stamps        (stamps),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_data     (push_data)
	);

	dstwr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	dstwr_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule
